### rtl/gdd_pkg.sv
// ----------------------------------------------------------------------------
// gdd_pkg
// Widths, constants and the month offset table for the day difference core.
// ----------------------------------------------------------------------------
package gdd_pkg;

  localparam int unsigned DayW      = 5;
  localparam int unsigned MonthW    = 4;
  localparam int unsigned YearW     = 14;
  localparam int unsigned CountW    = 22;
  // day number of a date, year field at its largest included
  localparam int unsigned DayNumW   = 23;
  localparam int unsigned CumW      = 9;

  // input and output tdata widths, padded to whole bytes
  localparam int unsigned InDataW   = 48;
  localparam int unsigned OutDataW  = 24;

  // reciprocal of 25 for a 13-bit dividend, exact up to well past 8191
  localparam int unsigned DivInW    = 13;
  localparam int unsigned DivQW     = 9;
  localparam int unsigned Recip25   = 5243;
  localparam int unsigned RecipSh   = 17;

  localparam logic [CountW-1:0] CountMax = '1;

  // days in the months before month m of a common year; months past
  // december count as thirty days
  function automatic logic [CumW-1:0] month_cum(input logic [MonthW-1:0] m);
    logic [CumW-1:0] c;
    unique case (m)
      4'd0, 4'd1: c = 9'd0;
      4'd2:       c = 9'd31;
      4'd3:       c = 9'd59;
      4'd4:       c = 9'd90;
      4'd5:       c = 9'd120;
      4'd6:       c = 9'd151;
      4'd7:       c = 9'd181;
      4'd8:       c = 9'd212;
      4'd9:       c = 9'd243;
      4'd10:      c = 9'd273;
      4'd11:      c = 9'd304;
      4'd12:      c = 9'd334;
      4'd13:      c = 9'd365;
      4'd14:      c = 9'd395;
      default:    c = 9'd425;
    endcase
    return c;
  endfunction

endpackage

### rtl/gdd_date_unit.sv
// ----------------------------------------------------------------------------
// gdd_date_unit
// Three-stage pipeline turning one date into its day number counted from
// year zero: year days and month offset, divisions by 25, leap and sum.
// ----------------------------------------------------------------------------
module gdd_date_unit (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [gdd_pkg::DayW-1:0]    day_i,
  input  logic [gdd_pkg::MonthW-1:0]  month_i,
  input  logic [gdd_pkg::YearW-1:0]   year_i,
  output logic [gdd_pkg::DayNumW-1:0] day_num_o
);
  import gdd_pkg::*;

  // quotient by 25 through a constant reciprocal
  function automatic logic [DivQW-1:0] div25(input logic [DivInW-1:0] x);
    logic [2*DivInW-1:0] p;
    p = {{DivInW{1'b0}}, x} * (2*DivInW)'(Recip25);
    return p[RecipSh +: DivQW];
  endfunction

  // stage 1 registers
  logic [DayW-1:0]    d_q,     d_d;
  logic [CumW-1:0]    cum_q,   cum_d;
  logic               mlate_q, mlate_d;
  logic [DayNumW-1:0] y365_q,  y365_d;
  logic [12:0]        s4_q,    s4_d;
  logic [12:0]        s100_q,  s100_d;
  logic [10:0]        s400_q,  s400_d;
  logic [11:0]        a1_q,    a1_d;
  logic [9:0]         b1_q,    b1_d;
  logic               y4z1_q,  y4z1_d;
  logic               y16z1_q, y16z1_d;

  // stage 2 registers
  logic [DayNumW-1:0] base_q,  base_d;
  logic [12:0]        q4_q,    q4_d;
  logic [DivQW-1:0]   q100_q,  q100_d;
  logic [DivQW-1:0]   q400_q,  q400_d;
  logic [DivQW-1:0]   qa_q,    qa_d;
  logic [DivQW-1:0]   qb_q,    qb_d;
  logic [11:0]        a2_q;
  logic [9:0]         b2_q;
  logic               y4z2_q;
  logic               y16z2_q;
  logic               mlate2_q;

  // stage 3 register
  logic [DayNumW-1:0] num_q,   num_d;

  logic [14:0] y_ext;
  logic        div100;
  logic        div400;
  logic        leap_adj;

  // stage 1: year days, rounded-up quarters and the month offset
  always_comb begin
    y_ext   = {1'b0, year_i};
    d_d     = day_i;
    cum_d   = month_cum(month_i);
    mlate_d = (month_i > 4'd2);
    y365_d  = {{(DayNumW-YearW){1'b0}}, year_i} * DayNumW'(365);
    s4_d    = 13'((y_ext + 15'd3) >> 2);
    s100_d  = 13'((y_ext + 15'd99) >> 2);
    s400_d  = 11'((y_ext + 15'd399) >> 4);
    a1_d    = year_i[13:2];
    b1_d    = year_i[13:4];
    y4z1_d  = (year_i[1:0] == 2'd0);
    y16z1_d = (year_i[3:0] == 4'd0);
  end

  // stage 2: divisions by 25 and the partial sum
  always_comb begin
    base_d = y365_q + {{(DayNumW-CumW){1'b0}}, cum_q} + {{(DayNumW-DayW){1'b0}}, d_q};
    q4_d   = s4_q;
    q100_d = div25(s100_q);
    q400_d = div25({2'b0, s400_q});
    qa_d   = div25({1'b0, a1_q});
    qb_d   = div25({3'b0, b1_q});
  end

  // stage 3: leap rule and the day number
  always_comb begin
    div100   = y4z2_q && ({1'b0, a2_q} == 13'({4'b0, qa_q} * 13'd25));
    div400   = y16z2_q && ({3'b0, b2_q} == 13'({4'b0, qb_q} * 13'd25));
    leap_adj = mlate2_q && (div400 || (y4z2_q && !div100));
    num_d    = base_q + {{(DayNumW-13){1'b0}}, q4_q}
             - {{(DayNumW-DivQW){1'b0}}, q100_q}
             + {{(DayNumW-DivQW){1'b0}}, q400_q}
             + {{(DayNumW-1){1'b0}}, leap_adj};
  end

  // payload registers, all advancing together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q      <= d_d;
      cum_q    <= cum_d;
      mlate_q  <= mlate_d;
      y365_q   <= y365_d;
      s4_q     <= s4_d;
      s100_q   <= s100_d;
      s400_q   <= s400_d;
      a1_q     <= a1_d;
      b1_q     <= b1_d;
      y4z1_q   <= y4z1_d;
      y16z1_q  <= y16z1_d;
      base_q   <= base_d;
      q4_q     <= q4_d;
      q100_q   <= q100_d;
      q400_q   <= q400_d;
      qa_q     <= qa_d;
      qb_q     <= qb_d;
      a2_q     <= a1_q;
      b2_q     <= b1_q;
      y4z2_q   <= y4z1_q;
      y16z2_q  <= y16z1_q;
      mlate2_q <= mlate_q;
      num_q    <= num_d;
    end
  end

  assign day_num_o = num_q;

endmodule

### rtl/gregorian_day_difference_core.sv
// ----------------------------------------------------------------------------
// gregorian_day_difference_core
// Days from a first Gregorian date to a second, with an order error flag.
//
// channel   dir  width  contents
// s_axis    in   48     date pair
// m_axis    out  24+1   day count, order error in tuser
//
// Four register stages: three in each date unit, then the output register.
// One date pair is taken in every cycle in which the pipeline advances.
// The whole pipeline advances whenever the output register is empty or its
// transfer completes; a stall freezes every stage in place.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module gregorian_day_difference_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // first_day, first_month, first_year, second_day, second_month,
  // second_year, zero pad
  input  logic [gdd_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // day_count, zero pad
  output logic [gdd_pkg::OutDataW-1:0] m_axis_tdata,
  // order_error
  output logic                         m_axis_tuser
);
  import gdd_pkg::*;

  logic [DayW-1:0]    d1, d2;
  logic [MonthW-1:0]  m1, m2;
  logic [YearW-1:0]   y1, y2;
  logic               adv;
  logic               later_in;
  logic [DayNumW-1:0] n1, n2;

  logic [2:0]         v_q,     v_d;
  logic [2:0]         later_q, later_d;
  logic               out_v_q, out_v_d;
  logic [CountW-1:0]  count_q, count_d;
  logic               err_q,   err_d;
  logic [DayNumW-1:0] diff;

  // unpack the date pair
  assign d1 = s_axis_tdata[4:0];
  assign m1 = s_axis_tdata[8:5];
  assign y1 = s_axis_tdata[22:9];
  assign d2 = s_axis_tdata[27:23];
  assign m2 = s_axis_tdata[31:28];
  assign y2 = s_axis_tdata[45:32];

  // advance when the output register is free or being drained
  assign adv           = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;

  // order compare: year, then month, then day
  assign later_in = ({y1, m1, d1} > {y2, m2, d2});

  gdd_date_unit u_first (
    .clk_i     (clk_i),
    .en_i      (adv),
    .day_i     (d1),
    .month_i   (m1),
    .year_i    (y1),
    .day_num_o (n1)
  );

  gdd_date_unit u_second (
    .clk_i     (clk_i),
    .en_i      (adv),
    .day_i     (d2),
    .month_i   (m2),
    .year_i    (y2),
    .day_num_o (n2)
  );

  // valid bits and order flag beside the date units
  always_comb begin
    v_d     = {v_q[1:0], s_axis_tvalid};
    later_d = {later_q[1:0], later_in};
  end

  // output stage: difference, clamp and error
  always_comb begin
    diff    = n2 - n1;
    out_v_d = v_q[2];
    err_d   = later_q[2];
    if (later_q[2] || (n2 <= n1)) begin
      count_d = '0;
    end else if (diff[DayNumW-1]) begin
      count_d = CountMax;
    end else begin
      count_d = diff[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v_q     <= v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      later_q <= later_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(OutDataW-CountW){1'b0}}, count_q};
  assign m_axis_tuser  = err_q;

  // an order error always carries a zero count
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && err_q) |-> (count_q == '0))
    else $error("order error with non-zero day count");

  // an accepted transfer enters the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v_q[0])
    else $error("accepted transfer lost at pipeline entry");

  // on advance the output takes the last stage's valid bit
  a_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (out_v_q == $past(v_q[2])))
    else $error("valid bit dropped or invented at output stage");

  // held output stays put while the sink stalls
  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(v_q) && $stable(count_q)))
    else $error("pipeline moved during a stall");

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level bench for the Gregorian day difference core. Date pairs go in
// through a randomly paced driver; a monitor with random back-pressure checks
// each day count and order error against an in-bench calculation of day
// numbers, in arrival order.
// ----------------------------------------------------------------------------
module tb_top;
  import gdd_pkg::*;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  // second date above first, first date in the low bits as on the bus
  typedef struct packed {
    date_t second;
    date_t first;
  } date_pair_t;

  typedef struct packed {
    logic              order_err;
    logic [CountW-1:0] count;
  } span_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;

  date_pair_t pending_pairs[$];
  span_t      expected_spans[$];
  int unsigned send_gap   = 0;
  int unsigned recv_stall = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned fault_cnt  = 0;
  span_t       want_span;
  span_t       got_span;

  gregorian_day_difference_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #12_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // day number calculation
  // ---------------------------------------------------------------------------
  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  // months other than 1..12 count as thirty days
  function automatic int unsigned month_len(int unsigned m, int unsigned y);
    if (m == 2) return leap_year(y) ? 29 : 28;
    if (m == 1 || m == 3 || m == 5 || m == 7 || m == 8 || m == 10 || m == 12) return 31;
    return 30;
  endfunction

  // days from the start of year zero, day field added as it stands
  function automatic longint unsigned day_ordinal(date_t dt);
    longint unsigned y;
    longint unsigned n;
    y = dt.year;
    n = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    for (int unsigned k = 1; k < dt.month; k++) n += month_len(k, dt.year);
    return n + dt.day;
  endfunction

  function automatic span_t predict_span(date_pair_t p);
    longint unsigned n1;
    longint unsigned n2;
    span_t s;
    // packed compare goes year, then month, then day
    s.order_err = (p.first > p.second);
    s.count     = '0;
    if (!s.order_err) begin
      n1 = day_ordinal(p.first);
      n2 = day_ordinal(p.second);
      if (n2 > n1) begin
        if (n2 - n1 > CountMax) s.count = CountMax;
        else                    s.count = CountW'(n2 - n1);
      end
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // mostly back to back, some short gaps, a few long ones; every fourth
  // window of the cycle counter, bits 9:8 at zero, runs with no idling at all
  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (cycle_cnt[9:8] == 2'b00) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic date_t random_date();
    date_t dt;
    dt.year  = YearW'($urandom_range(1, 9999));
    dt.month = MonthW'($urandom_range(1, 12));
    dt.day   = DayW'($urandom_range(1, month_len(dt.month, dt.year)));
    return dt;
  endfunction

  // well-formed pairs, often in one year or month, with raw noise mixed in
  function automatic date_pair_t random_pair();
    int unsigned r;
    date_t a;
    date_t b;
    date_t t;
    date_pair_t p;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      p = date_pair_t'({$urandom, $urandom});
    end else begin
      a = random_date();
      b = random_date();
      if (r < 45) b.year = a.year;
      if (r < 30) b.month = a.month;
      b.day = DayW'($urandom_range(1, month_len(b.month, b.year)));
      // a tenth keep whatever order they fell in
      if (a > b && ($urandom_range(0, 9) != 0)) begin
        t = a;
        a = b;
        b = t;
      end
      p.first  = a;
      p.second = b;
    end
    return p;
  endfunction

  task automatic push_dates(int unsigned d1, int unsigned m1, int unsigned y1,
                            int unsigned d2, int unsigned m2, int unsigned y2);
    date_pair_t p;
    p.first  = {YearW'(y1), MonthW'(m1), DayW'(d1)};
    p.second = {YearW'(y2), MonthW'(m2), DayW'(d2)};
    pending_pairs.push_back(p);
  endtask

  task automatic report_fault(string msg);
    fault_cnt++;
    if (fault_cnt <= 10) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    // same date, full span, order errors on year, month and day
    push_dates(15, 6, 2010, 15, 6, 2010);
    push_dates(1, 1, 1, 31, 12, 9999);
    push_dates(1, 1, 2001, 31, 12, 2000);
    push_dates(1, 7, 2000, 30, 6, 2000);
    push_dates(12, 5, 1999, 11, 5, 1999);
    // leap rule: four hundred, hundred, four
    push_dates(28, 2, 2000, 1, 3, 2000);
    push_dates(28, 2, 1900, 1, 3, 1900);
    push_dates(28, 2, 2024, 1, 3, 2024);
    push_dates(1, 1, 1999, 1, 1, 2000);
    // unchecked days, and a negative span with dates in order
    push_dates(0, 3, 2004, 31, 2, 2004);
    push_dates(31, 2, 2001, 1, 3, 2001);
    // months outside the calendar
    push_dates(5, 0, 100, 5, 13, 100);
    push_dates(1, 14, 300, 1, 15, 300);
    // year zero, years past 9999, saturation
    push_dates(1, 1, 0, 1, 1, 1);
    push_dates(0, 0, 0, 31, 15, 16383);
    push_dates(1, 1, 10000, 1, 1, 16383);
    push_dates(31, 15, 16383, 31, 15, 16383);
    push_dates(0, 0, 0, 0, 0, 0);
    push_dates(31, 15, 16383, 0, 0, 0);
    push_dates(31, 12, 9999, 1, 1, 1);
    for (int i = 0; i < 1400; i++) pending_pairs.push_back(random_pair());

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_pairs.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_spans.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    if (expected_spans.size() != 0)
      report_fault($sformatf("%0d expected results never arrived", expected_spans.size()));
    if (fault_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // input driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else begin
      // accepted transfer: record what it should produce
      if (s_axis_tvalid && s_axis_tready)
        expected_spans.push_back(predict_span(date_pair_t'(s_axis_tdata[2*$bits(date_t)-1:0])));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          s_axis_tdata  <= InDataW'(pending_pairs.pop_front());
          s_axis_tvalid <= 1'b1;
          send_gap      <= next_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output monitor with back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_span.count     = m_axis_tdata[CountW-1:0];
        got_span.order_err = m_axis_tuser;
        if (expected_spans.size() == 0) begin
          report_fault($sformatf("unexpected result: day_count %0d order_error %0b",
                                 got_span.count, got_span.order_err));
        end else begin
          want_span = expected_spans.pop_front();
          if (got_span.count !== want_span.count)
            report_fault($sformatf("day_count mismatch: expected %0d, got %0d",
                                   want_span.count, got_span.count));
          if (got_span.order_err !== want_span.order_err)
            report_fault($sformatf("order_error mismatch: expected %0b, got %0b",
                                   want_span.order_err, got_span.order_err));
        end
      end
      if (recv_stall != 0) begin
        recv_stall    <= recv_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_stall    <= next_gap();
      end
    end
  end

endmodule
